// ===== hdl/ocsd_pkg.sv =====
`default_nettype none
package ocsd_pkg;

  localparam int CODE_MAP_DEPTH_DEF = 128;
  localparam int DELAY_BITS_DEF     = 24;

  localparam int REQ_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 7;
  localparam int PORT_W      = 2;
  localparam int DELAY_OUT_W = 24;
  localparam int ADD_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 32;
  localparam int S_DATA_W    = 24;
  localparam int M_DATA_W    = 32;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BYTE    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_CODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = 2'd3;

  localparam logic [BYTE_W-1:0] CMD_SHORT_DELAY = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_LONG_DELAY  = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_BANK_LOW    = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_BANK_HIGH   = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_ESCAPE      = 8'h04;

  typedef struct packed {
    logic [PORT_W-1:0]      port;
    logic [BYTE_W-1:0]      data;
    logic [DELAY_OUT_W-1:0] delay_ms;
    logic                   last;
  } row_t;

endpackage
`default_nettype wire

// ===== hdl/ocsd_ram.sv =====
`default_nettype none
module ocsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/ocsd_parse.sv =====
`default_nettype none
module ocsd_parse #(
  parameter int CODE_MAP_DEPTH = 128,
  parameter int DELAY_BITS     = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ocsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ocsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            go,
  input  wire logic [ocsd_pkg::REQ_W-1:0]      req_type,
  input  wire logic [ocsd_pkg::INDEX_W-1:0]    map_index,
  input  wire logic [ocsd_pkg::BYTE_W-1:0]     map_value,
  input  wire logic [ocsd_pkg::BYTE_W-1:0]     body_byte,
  output logic                                 emit,
  output ocsd_pkg::row_t                       row_addr,
  output ocsd_pkg::row_t                       row_data
);
  import ocsd_pkg::*;

  localparam int MAP_AW = (CODE_MAP_DEPTH > 1) ? $clog2(CODE_MAP_DEPTH) : 1;
  localparam logic [DELAY_BITS-1:0] DELAY_TOP = '1;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SHORT, PH_LONG_LO, PH_LONG_HI, PH_ESC_REG, PH_VALUE, PH_PAIR_VAL
  } phase_t;

  logic                  version_two_mode;
  logic [BYTE_W-1:0]     short_delay_code;
  logic [BYTE_W-1:0]     long_delay_code;
  logic [COUNT_W-1:0]    body_length;

  phase_t                phase, phase_next;
  logic                  bank_high, bank_high_next;
  logic [BYTE_W-1:0]     held_register, held_register_next;
  logic [BYTE_W-1:0]     held_delay_low, held_delay_low_next;
  logic [DELAY_BITS-1:0] delay_acc, delay_acc_next;
  logic                  any_write_done, any_write_done_next;
  logic [COUNT_W-1:0]    consumed_count, consumed_count_next;

  logic [CODE_MAP_DEPTH-1:0] map_valid;
  logic                      fwd_hit;
  logic [BYTE_W-1:0]         fwd_data;
  logic [BYTE_W-1:0]         ram_rdata;
  logic                      load_we;
  logic [MAP_AW-1:0]         load_addr;
  logic [MAP_AW-1:0]         look_addr;
  logic [MAP_AW-1:0]         look_addr_next;
  logic                      look_in_range;
  logic [BYTE_W-1:0]         map_word;

  logic                  is_byte;
  logic                  do_add;
  logic [ADD_W-1:0]      add_ms;
  logic [DELAY_BITS:0]   delay_sum;
  logic                  write_high;
  logic [BYTE_W-1:0]     write_reg;

  assign load_we   = go && (req_type == REQ_LOAD) &&
                     ({1'b0, map_index} < 8'(CODE_MAP_DEPTH));
  assign load_addr = map_index[MAP_AW-1:0];

  assign look_addr      = held_register[MAP_AW-1:0];
  assign look_addr_next = held_register_next[MAP_AW-1:0];
  assign look_in_range  = ({1'b0, held_register[INDEX_W-1:0]} < 8'(CODE_MAP_DEPTH));
  assign map_word = (look_in_range && map_valid[look_addr]) ?
                    (fwd_hit ? fwd_data : ram_rdata) : '0;

  ocsd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CODE_MAP_DEPTH),
    .AW    (MAP_AW)
  ) u_map (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (map_value),
    .raddr (look_addr_next),
    .rdata (ram_rdata)
  );

  assign is_byte = go && (req_type == REQ_BYTE) && (consumed_count < body_length);

  always_comb begin
    phase_next          = phase;
    bank_high_next      = bank_high;
    held_register_next  = held_register;
    held_delay_low_next = held_delay_low;
    any_write_done_next = any_write_done;
    consumed_count_next = consumed_count;
    do_add              = 1'b0;
    add_ms              = '0;
    emit                = 1'b0;
    write_high          = bank_high;
    write_reg           = held_register;

    if (go && (req_type == REQ_RESTART)) begin
      phase_next          = PH_IDLE;
      bank_high_next      = 1'b0;
      held_register_next  = '0;
      held_delay_low_next = '0;
      any_write_done_next = 1'b0;
      consumed_count_next = '0;
    end else if (is_byte && !version_two_mode) begin
      consumed_count_next = consumed_count + 1'b1;
      phase_next          = PH_IDLE;
      unique case (phase)
        PH_SHORT: begin
          do_add = 1'b1;
          add_ms = ADD_W'(body_byte) + 1'b1;
        end
        PH_LONG_LO: begin
          held_delay_low_next = body_byte;
          phase_next          = PH_LONG_HI;
        end
        PH_LONG_HI: begin
          do_add = 1'b1;
          add_ms = {1'b0, body_byte, held_delay_low} + 1'b1;
        end
        PH_ESC_REG: begin
          held_register_next = body_byte;
          phase_next         = PH_VALUE;
        end
        PH_VALUE: begin
          emit = 1'b1;
        end
        default: begin
          unique case (body_byte)
            CMD_SHORT_DELAY: phase_next = PH_SHORT;
            CMD_LONG_DELAY:  phase_next = PH_LONG_LO;
            CMD_BANK_LOW:    bank_high_next = 1'b0;
            CMD_BANK_HIGH:   bank_high_next = 1'b1;
            CMD_ESCAPE:      phase_next = PH_ESC_REG;
            default: begin
              held_register_next = body_byte;
              phase_next         = PH_VALUE;
            end
          endcase
        end
      endcase
    end else if (is_byte) begin
      if (phase != PH_PAIR_VAL) begin
        held_register_next = body_byte;
        phase_next         = PH_PAIR_VAL;
      end else begin
        phase_next          = PH_IDLE;
        consumed_count_next = consumed_count + 1'b1;
        if (held_register == short_delay_code) begin
          do_add = 1'b1;
          add_ms = ADD_W'(body_byte) + 1'b1;
        end else if (held_register == long_delay_code) begin
          do_add = 1'b1;
          add_ms = {ADD_W'(body_byte) + 1'b1} << 8;
        end else begin
          emit       = 1'b1;
          write_high = held_register[BYTE_W-1];
          write_reg  = map_word;
        end
      end
    end

    if (cfg_we && (cfg_index == CFG_MODE)) begin
      phase_next = PH_IDLE;
    end

    delay_sum = {1'b0, delay_acc} + (DELAY_BITS+1)'(add_ms);
    if (go && (req_type == REQ_RESTART)) begin
      delay_acc_next = '0;
    end else if (emit) begin
      delay_acc_next      = '0;
      any_write_done_next = 1'b1;
    end else if (do_add) begin
      delay_acc_next = delay_sum[DELAY_BITS] ? DELAY_TOP : delay_sum[DELAY_BITS-1:0];
    end else begin
      delay_acc_next = delay_acc;
    end

    row_addr.port     = {write_high, 1'b0};
    row_addr.data     = write_reg;
    row_addr.delay_ms = any_write_done ? DELAY_OUT_W'(delay_acc) : '0;
    row_addr.last     = 1'b0;
    row_data.port     = {write_high, 1'b1};
    row_data.data     = body_byte;
    row_data.delay_ms = '0;
    row_data.last     = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version_two_mode <= 1'b0;
      short_delay_code <= 8'h00;
      long_delay_code  <= 8'h01;
      body_length      <= '0;
      phase            <= PH_IDLE;
      bank_high        <= 1'b0;
      held_register    <= '0;
      held_delay_low   <= '0;
      delay_acc        <= '0;
      any_write_done   <= 1'b0;
      consumed_count   <= '0;
      map_valid        <= '0;
      fwd_hit          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:        version_two_mode <= cfg_data[0];
          CFG_SHORT_CODE:  short_delay_code <= cfg_data[BYTE_W-1:0];
          CFG_LONG_CODE:   long_delay_code  <= cfg_data[BYTE_W-1:0];
          CFG_BODY_LENGTH: body_length      <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      phase          <= phase_next;
      bank_high      <= bank_high_next;
      held_register  <= held_register_next;
      held_delay_low <= held_delay_low_next;
      delay_acc      <= delay_acc_next;
      any_write_done <= any_write_done_next;
      consumed_count <= consumed_count_next;
      if (load_we) begin
        map_valid[load_addr] <= 1'b1;
      end
      fwd_hit <= load_we && (load_addr == look_addr_next);
    end
    fwd_data <= map_value;
  end

endmodule
`default_nettype wire

// ===== hdl/ocsd_row_fifo.sv =====
`default_nettype none
module ocsd_row_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  ocsd_pkg::row_t      row_first,
  input  ocsd_pkg::row_t      row_second,
  output logic                room,
  output logic                out_valid,
  output ocsd_pkg::row_t      out_row,
  input  wire logic           pop
);
  import ocsd_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  row_t          rows [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_pop;

  assign room      = (count <= (PW+1)'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_row   = rows[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(2);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (push ? (PW+1)'(2) : '0) - ((PW+1)'(do_pop));
    end
    if (push) begin
      rows[wr_ptr]        <= row_first;
      rows[wr_ptr + 1'b1] <= row_second;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/opl_capture_stream_decoder_top.sv =====
// Items pass the input register; a write's two rows are then pushed into the row queue.
// Throughput: one item per cycle; each register write yields two rows, one per cycle while
// m_tready is high, in a four-row queue that stalls input only when it can't take a pair.
// Reset: synchronous, active high; clears parser state, registers and code map valid bits,
// so every code map entry reads as zero until loaded. No clearing pass is needed.
`default_nettype none
module opl_capture_stream_decoder_top #(
  parameter int CODE_MAP_DEPTH = ocsd_pkg::CODE_MAP_DEPTH_DEF,
  parameter int DELAY_BITS     = ocsd_pkg::DELAY_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ocsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ocsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // map_index [6:0], map_value [14:7], body_byte [22:15], zero [23]
  input  wire logic [ocsd_pkg::S_DATA_W-1:0]   s_tdata,
  // req_type [1:0]
  input  wire logic [ocsd_pkg::REQ_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // out_data [7:0], delay_before_ms [31:8]
  output logic      [ocsd_pkg::M_DATA_W-1:0]   m_tdata,
  // out_port [1:0]
  output logic      [ocsd_pkg::PORT_W-1:0]     m_tuser,
  output logic                                 m_tlast
);
  import ocsd_pkg::*;

  logic               in_valid;
  logic [REQ_W-1:0]   in_req;
  logic [S_DATA_W-1:0] in_data;
  logic               room;
  logic               advance;
  logic               emit;
  row_t               row_addr;
  row_t               row_data;
  row_t               out_row;

  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_data <= s_tdata;
    end
  end

  ocsd_parse #(
    .CODE_MAP_DEPTH (CODE_MAP_DEPTH),
    .DELAY_BITS     (DELAY_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (advance),
    .req_type  (in_req),
    .map_index (in_data[6:0]),
    .map_value (in_data[14:7]),
    .body_byte (in_data[22:15]),
    .emit      (emit),
    .row_addr  (row_addr),
    .row_data  (row_data)
  );

  ocsd_row_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (advance && emit),
    .row_first  (row_addr),
    .row_second (row_data),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_row    (out_row),
    .pop        (m_tready)
  );

  assign m_tdata = {out_row.delay_ms, out_row.data};
  assign m_tuser = out_row.port;
  assign m_tlast = out_row.last;

endmodule
`default_nettype wire

// ===== hdl/ocsd_checker.sv =====
`default_nettype none
module ocsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // The queue is empty straight after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("row offered directly after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("stalled row changed");

  // The data row of a pair is always queued together with its address row.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tlast && m_tuser[0] && (m_tuser[1] == $past(m_tuser[1]))))
    else $error("address row not followed by its data row");

  a_row_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tlast && m_tuser[0] && (m_tdata[31:8] == 24'd0)) ||
                  (!m_tlast && !m_tuser[0])))
    else $error("row port, last flag and delay disagree");

endmodule

bind opl_capture_stream_decoder_top ocsd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== verif/ocsd_row_checker.sv =====
`timescale 1ns / 100ps
module ocsd_row_checker
  import ocsd_pkg::*;
#(
  parameter int CODE_MAP_DEPTH = CODE_MAP_DEPTH_DEF,
  parameter int DELAY_BITS     = DELAY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,
  input  logic [REQ_W-1:0]      s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,
  input  logic [PORT_W-1:0]     m_tuser,
  input  logic                  m_tlast,
  output int                    error_count,
  output int                    rows_outstanding
);

  localparam logic [PORT_W-1:0] PORT_LOW_ADDR  = 2'd0;
  localparam logic [PORT_W-1:0] PORT_LOW_DATA  = 2'd1;
  localparam logic [PORT_W-1:0] PORT_HIGH_ADDR = 2'd2;
  localparam logic [PORT_W-1:0] PORT_HIGH_DATA = 2'd3;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SHORT, PH_LONG_LO, PH_LONG_HI, PH_ESC_REG, PH_VALUE, PH_PAIR_VAL
  } phase_t;

  logic                  pair_mode;
  logic [BYTE_W-1:0]     short_code;
  logic [BYTE_W-1:0]     long_code;
  logic [COUNT_W-1:0]    body_len;
  phase_t                phase;
  logic                  bank_hi;
  logic [BYTE_W-1:0]     held_reg;
  logic [BYTE_W-1:0]     held_lo;
  logic [DELAY_BITS-1:0] delay_acc;
  logic                  wrote_once;
  logic [COUNT_W-1:0]    consumed;
  logic [BYTE_W-1:0]     code_map [CODE_MAP_DEPTH];
  row_t                  expected_rows [$];
  int                    mismatches = 0;

  function automatic void restart_parser();
    phase      = PH_IDLE;
    bank_hi    = 1'b0;
    held_reg   = '0;
    held_lo    = '0;
    delay_acc  = '0;
    wrote_once = 1'b0;
    consumed   = '0;
  endfunction

  function automatic void reset_decoder();
    pair_mode  = 1'b0;
    short_code = CMD_SHORT_DELAY;
    long_code  = CMD_LONG_DELAY;
    body_len   = '0;
    restart_parser();
    for (int i = 0; i < CODE_MAP_DEPTH; i++) code_map[i] = '0;
  endfunction

  function automatic void add_delay(input logic [31:0] ms);
    logic [32:0] sum;
    logic [32:0] ceiling;
    ceiling = (33'd1 << DELAY_BITS) - 33'd1;
    sum = {1'b0, 32'(delay_acc)} + {1'b0, ms};
    if (sum > ceiling) delay_acc = '1;
    else delay_acc = sum[DELAY_BITS-1:0];
  endfunction

  function automatic void queue_write(input logic high, input logic [BYTE_W-1:0] reg_num,
                                      input logic [BYTE_W-1:0] value);
    row_t addr_row;
    row_t data_row;
    addr_row.port     = high ? PORT_HIGH_ADDR : PORT_LOW_ADDR;
    addr_row.data     = reg_num;
    addr_row.delay_ms = wrote_once ? DELAY_OUT_W'(delay_acc) : '0;
    addr_row.last     = 1'b0;
    data_row.port     = high ? PORT_HIGH_DATA : PORT_LOW_DATA;
    data_row.data     = value;
    data_row.delay_ms = '0;
    data_row.last     = 1'b1;
    expected_rows.push_back(addr_row);
    expected_rows.push_back(data_row);
    delay_acc  = '0;
    wrote_once = 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] mapped_register(input logic [BYTE_W-1:0] code);
    int idx;
    idx = int'(code[6:0]);
    return (idx < CODE_MAP_DEPTH) ? code_map[idx] : '0;
  endfunction

  function automatic void command_byte(input logic [BYTE_W-1:0] b);
    consumed = consumed + 1;
    case (phase)
      PH_SHORT: begin
        add_delay(32'(b) + 32'd1);
        phase = PH_IDLE;
      end
      PH_LONG_LO: begin
        held_lo = b;
        phase = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        add_delay(32'({b, held_lo}) + 32'd1);
        phase = PH_IDLE;
      end
      PH_ESC_REG: begin
        held_reg = b;
        phase = PH_VALUE;
      end
      PH_VALUE: begin
        phase = PH_IDLE;
        queue_write(bank_hi, held_reg, b);
      end
      default: begin
        phase = PH_IDLE;
        case (b)
          CMD_SHORT_DELAY: phase = PH_SHORT;
          CMD_LONG_DELAY:  phase = PH_LONG_LO;
          CMD_BANK_LOW:    bank_hi = 1'b0;
          CMD_BANK_HIGH:   bank_hi = 1'b1;
          CMD_ESCAPE:      phase = PH_ESC_REG;
          default: begin
            held_reg = b;
            phase = PH_VALUE;
          end
        endcase
      end
    endcase
  endfunction

  function automatic void pair_byte(input logic [BYTE_W-1:0] b);
    if (phase != PH_PAIR_VAL) begin
      held_reg = b;
      phase = PH_PAIR_VAL;
    end else begin
      phase = PH_IDLE;
      consumed = consumed + 1;
      if (held_reg == short_code) add_delay(32'(b) + 32'd1);
      else if (held_reg == long_code) add_delay((32'(b) + 32'd1) << 8);
      else queue_write(held_reg[7], mapped_register(held_reg), b);
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MODE: begin
        pair_mode = value[0];
        phase = PH_IDLE;
      end
      CFG_SHORT_CODE:  short_code = value[BYTE_W-1:0];
      CFG_LONG_CODE:   long_code = value[BYTE_W-1:0];
      CFG_BODY_LENGTH: body_len = value[COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_rows(input logic [REQ_W-1:0] req,
                                       input logic [INDEX_W-1:0] idx,
                                       input logic [BYTE_W-1:0] map_val,
                                       input logic [BYTE_W-1:0] b);
    case (req)
      REQ_LOAD: if (int'(idx) < CODE_MAP_DEPTH) code_map[idx] = map_val;
      REQ_RESTART: restart_parser();
      REQ_BYTE: begin
        if (consumed < body_len) begin
          if (pair_mode) pair_byte(b);
          else command_byte(b);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%t ERROR %s", $realtime, msg);
  endfunction

  function automatic void check_row(input row_t got);
    row_t want;
    if (expected_rows.size() == 0) begin
      flag_error($sformatf("unexpected row: port %0d data %02h delay %0d last %0b",
                           got.port, got.data, got.delay_ms, got.last));
    end else begin
      want = expected_rows.pop_front();
      if (got.port !== want.port || got.data !== want.data ||
          got.delay_ms !== want.delay_ms || got.last !== want.last)
        flag_error($sformatf({"row mismatch: expected port %0d data %02h delay %0d last %0b,",
                              " got port %0d data %02h delay %0d last %0b"},
                             want.port, want.data, want.delay_ms, want.last,
                             got.port, got.data, got.delay_ms, got.last));
    end
  endfunction

  always @(posedge clk) begin : watch
    row_t got;
    got.port     = m_tuser;
    got.data     = m_tdata[7:0];
    got.delay_ms = m_tdata[31:8];
    got.last     = m_tlast;
    if (rst) begin
      reset_decoder();
      expected_rows.delete();
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        predict_rows(s_tuser, s_tdata[6:0], s_tdata[14:7], s_tdata[22:15]);
      if (m_tvalid && m_tready) check_row(got);
    end
    rows_outstanding <= expected_rows.size();
    error_count <= mismatches;
  end

endmodule

// ===== verif/opl_capture_stream_decoder_top_tb.sv =====
`timescale 1ns / 100ps
module opl_capture_stream_decoder_top_tb;
  import ocsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;
  logic [REQ_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [PORT_W-1:0]     m_tuser;
  logic                  m_tlast;

  int error_count;
  int rows_outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  int send_gap_pct = 28;
  int sink_stall_pct = 28;
  int hold_off_cycles = 0;

  opl_capture_stream_decoder_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  ocsd_row_checker checker_inst (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .error_count(error_count), .rows_outstanding(rows_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("opl_capture_stream_decoder_top_tb: done, errors");
      $finish;
    end
  end

  // The receiver stalls at random, or holds off for a whole stretch when asked.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end else m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic offer_item(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] map_val, input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {1'b0, b, map_val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    offer_item(REQ_BYTE, 7'($urandom), 8'($urandom), b);
  endtask

  task automatic send_other(input logic [REQ_W-1:0] req);
    offer_item(req, 7'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (rows_outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic command_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(5, 255)));
      send_byte(8'($urandom));
    end else if (pick < 50) begin
      send_byte(CMD_SHORT_DELAY);
      send_byte(8'($urandom));
    end else if (pick < 58) begin
      send_byte(CMD_LONG_DELAY);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else if (pick < 66) begin
      send_byte($urandom_range(1) ? CMD_BANK_HIGH : CMD_BANK_LOW);
    end else if (pick < 76) begin
      send_byte(CMD_ESCAPE);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else if (pick < 82) begin
      send_other(REQ_LOAD);
    end else if (pick < 85) begin
      send_other(REQ_RESTART);
    end else if (pick < 88) begin
      send_other(REQ_UNKNOWN);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic pair_sequence(input logic [BYTE_W-1:0] short_code,
                               input logic [BYTE_W-1:0] long_code);
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end else if (pick < 65) begin
      send_byte(short_code);
      send_byte(8'($urandom));
    end else if (pick < 75) begin
      send_byte(long_code);
      send_byte(8'($urandom));
    end else if (pick < 83) begin
      send_other(REQ_LOAD);
    end else if (pick < 86) begin
      send_other(REQ_RESTART);
    end else if (pick < 89) begin
      send_other(REQ_UNKNOWN);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic run_commands(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) command_sequence();
  endtask

  task automatic run_pairs(input int count, input logic [BYTE_W-1:0] short_code,
                           input logic [BYTE_W-1:0] long_code);
    int target;
    target = items_sent + count;
    while (items_sent < target) pair_sequence(short_code, long_code);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_LOAD;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(CFG_BODY_LENGTH, 32'hFFFF_FFFF);
    write_register(CFG_MODE, 32'd0);

    offer_item(REQ_LOAD, 7'd0, 8'hA5, 8'h00);
    offer_item(REQ_LOAD, 7'h7F, 8'hFF, 8'hFF);
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(CMD_SHORT_DELAY);
    send_byte(8'hFF);
    send_byte(CMD_LONG_DELAY);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(CMD_BANK_HIGH);
    send_byte(CMD_ESCAPE);
    send_byte(CMD_BANK_LOW);
    send_byte(8'hFF);
    send_byte(CMD_BANK_LOW);
    send_byte(8'hFF);
    send_byte(8'h80);
    offer_item(REQ_UNKNOWN, 7'h7F, 8'hFF, 8'hFF);
    send_byte(CMD_LONG_DELAY);
    send_byte(8'h00);
    offer_item(REQ_RESTART, 7'h00, 8'h00, 8'h00);
    drain();

    // With a zero body length every byte is ignored.
    write_register(CFG_BODY_LENGTH, 32'd0);
    run_commands(20);
    drain();
    write_register(CFG_BODY_LENGTH, 32'hFFFF_FFFF);
    run_commands(60);

    send_gap_pct = 0;
    hold_off_cycles = 150;
    run_commands(80);
    send_gap_pct = 28;
    drain();
    run_commands(60);
    drain();

    write_register(CFG_MODE, 32'd1);
    write_register(CFG_SHORT_CODE, 32'd255);
    write_register(CFG_LONG_CODE, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h11);
    send_byte(8'h7F);
    send_byte(8'h22);
    run_pairs(100, 8'hFF, 8'h00);
    drain();

    // Both delay codes equal, with neither side idling.
    send_gap_pct = 0;
    sink_stall_pct = 0;
    write_register(CFG_SHORT_CODE, 32'h55);
    write_register(CFG_LONG_CODE, 32'h55);
    run_pairs(120, 8'h55, 8'h55);
    drain();
    send_gap_pct = 28;
    sink_stall_pct = 28;

    // Enough long delays to drive the accumulated delay into saturation.
    write_register(CFG_SHORT_CODE, 32'h80);
    write_register(CFG_LONG_CODE, 32'h81);
    send_other(REQ_RESTART);
    send_byte(8'h23);
    send_byte(8'($urandom));
    for (int i = 0; i < 275; i++) begin
      send_byte(8'h81);
      send_byte(8'($urandom_range(240, 255)));
    end
    send_byte(8'h24);
    send_byte(8'($urandom));
    send_byte(8'h25);
    send_byte(8'($urandom));
    drain();

    write_register(CFG_MODE, 32'd0);
    write_register(CFG_BODY_LENGTH, 32'($urandom_range(20, 60)));
    send_other(REQ_RESTART);
    run_commands(60);
    drain();

    write_register(CFG_MODE, 32'd1);
    write_register(CFG_BODY_LENGTH, 32'($urandom_range(10, 30)));
    send_other(REQ_RESTART);
    run_pairs(60, 8'h80, 8'h81);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("opl_capture_stream_decoder_top_tb: done, clean");
    else $display("opl_capture_stream_decoder_top_tb: done, errors");
    $finish;
  end

endmodule

// ===== opl_capture_stream_decoder_top.f =====
hdl/ocsd_pkg.sv
hdl/ocsd_ram.sv
hdl/ocsd_parse.sv
hdl/ocsd_row_fifo.sv
hdl/opl_capture_stream_decoder_top.sv
hdl/ocsd_checker.sv
verif/ocsd_row_checker.sv
verif/opl_capture_stream_decoder_top_tb.sv
